### rtl/core/ndccag_pkg.sv
// shared types, widths and codes for the nd chunk copy address generator
// used by ndccag_ctrl, ndccag_dp and nd_chunk_copy_address_generator
package ndccag_pkg;

  localparam int MAX_DIMS  = 3;
  localparam int DIM_W     = 16;
  localparam int STRIDE_W  = 2 * DIM_W;
  localparam int OFF_W     = 52;
  localparam int RUN_W     = 20;
  localparam int ITEM_W    = 5;
  localparam int MAX_ITEM  = 16;
  localparam int DIMS_W    = 2;
  localparam int CFG_IDX_W = 3;

  typedef logic [DIM_W-1:0]    dim_t;
  typedef logic [STRIDE_W-1:0] stride_t;
  typedef logic [OFF_W-1:0]    off_t;
  typedef logic [RUN_W-1:0]    run_t;
  typedef logic [ITEM_W-1:0]   item_t;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COORD = 2'd1,
    ST_NOACT = 2'd2
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM0      = 3'd0,
    CFG_DIM1      = 3'd1,
    CFG_DIM2      = 3'd2,
    CFG_CHUNK0    = 3'd3,
    CFG_CHUNK1    = 3'd4,
    CFG_CHUNK2    = 3'd5,
    CFG_ITEM      = 3'd6,
    CFG_DIMS_USED = 3'd7
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic    latch_start;
    logic    grid;
    logic    clip;
    logic    term;
    logic    sum;
    logic    load_run;
    logic    load_err;
    status_t err_code;
    logic    advance;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic coord_err;
    logic last;
  } dp_stat_t;

endpackage

### rtl/core/nd_chunk_copy_address_generator.sv
// nd chunk copy address generator top level
// a start steps through the grid, clip, term, sum and output states, a next through term, sum and
// output; a start outside the grid goes from clip to the error state, a next with no active chunk
// goes straight to it; a new request is taken only in idle, after the previous result is loaded,
// and a held result stalls the output and error states
// reset: synchronous active low; sizes 1, item size 1, three dims used, no active chunk
module nd_chunk_copy_address_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ndccag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ndccag_pkg::DIM_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_req_type,
  input  logic [ndccag_pkg::DIM_W-1:0]         in_coord0,
  input  logic [ndccag_pkg::DIM_W-1:0]         in_coord1,
  input  logic [ndccag_pkg::DIM_W-1:0]         in_coord2,
  input  logic                                 in_to_chunk,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ndccag_pkg::OFF_W-1:0]         out_array_offset,
  output logic [ndccag_pkg::OFF_W-1:0]         out_chunk_offset,
  output logic [ndccag_pkg::RUN_W-1:0]         out_run_bytes,
  output logic                                 out_direction,
  output logic                                 out_last,
  output logic [1:0]                           out_status
);

  ndccag_pkg::dp_cmd_t  cmd;
  ndccag_pkg::dp_stat_t stat;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencing
  ndccag_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // address arithmetic and result register
  ndccag_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_coord0        (in_coord0),
    .in_coord1        (in_coord1),
    .in_coord2        (in_coord2),
    .in_to_chunk      (in_to_chunk),
    .cmd              (cmd),
    .stat             (stat),
    .out_array_offset (out_array_offset),
    .out_chunk_offset (out_chunk_offset),
    .out_run_bytes    (out_run_bytes),
    .out_direction    (out_direction),
    .out_last         (out_last),
    .out_status       (out_status)
  );

endmodule

### rtl/core/ndccag_dp.sv
// datapath: config registers, chunk clipping, strides, run offsets, result register
// depends on ndccag_pkg; driven by ndccag_ctrl through dp_cmd_t
module ndccag_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ndccag_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ndccag_pkg::DIM_W-1:0]          cfg_data,
  input  logic [ndccag_pkg::DIM_W-1:0]          in_coord0,
  input  logic [ndccag_pkg::DIM_W-1:0]          in_coord1,
  input  logic [ndccag_pkg::DIM_W-1:0]          in_coord2,
  input  logic                                  in_to_chunk,
  input  ndccag_pkg::dp_cmd_t                   cmd,
  output ndccag_pkg::dp_stat_t                  stat,
  output logic [ndccag_pkg::OFF_W-1:0]          out_array_offset,
  output logic [ndccag_pkg::OFF_W-1:0]          out_chunk_offset,
  output logic [ndccag_pkg::RUN_W-1:0]          out_run_bytes,
  output logic                                  out_direction,
  output logic                                  out_last,
  output logic [1:0]                            out_status
);

  localparam int DW   = ndccag_pkg::DIM_W;
  localparam int SW   = ndccag_pkg::STRIDE_W;
  localparam int OW   = ndccag_pkg::OFF_W;
  localparam int T0_W = DW + 1 + SW;
  localparam int T1_W = DW + 1 + DW;
  localparam int C0_W = DW + SW;
  localparam int C1_W = 2 * DW;

  // configuration registers
  ndccag_pkg::dim_t  dim_r [3];
  ndccag_pkg::dim_t  chk_r [3];
  ndccag_pkg::item_t item_r;
  logic [ndccag_pkg::DIMS_W-1:0] dims_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        dim_r[k] <= ndccag_pkg::dim_t'(1);
        chk_r[k] <= ndccag_pkg::dim_t'(1);
      end
      item_r      <= ndccag_pkg::item_t'(1);
      dims_used_r <= ndccag_pkg::DIMS_W'(3);
    end else if (cfg_we) begin
      unique case (ndccag_pkg::cfg_idx_t'(cfg_index))
        ndccag_pkg::CFG_DIM0:      dim_r[0] <= cfg_data;
        ndccag_pkg::CFG_DIM1:      dim_r[1] <= cfg_data;
        ndccag_pkg::CFG_DIM2:      dim_r[2] <= cfg_data;
        ndccag_pkg::CFG_CHUNK0:    chk_r[0] <= cfg_data;
        ndccag_pkg::CFG_CHUNK1:    chk_r[1] <= cfg_data;
        ndccag_pkg::CFG_CHUNK2:    chk_r[2] <= cfg_data;
        ndccag_pkg::CFG_ITEM:      item_r <= cfg_data[ndccag_pkg::ITEM_W-1:0];
        ndccag_pkg::CFG_DIMS_USED: dims_used_r <= cfg_data[ndccag_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes: unused leading dims and zero sizes act as one, item size capped at MAX_ITEM
  logic [ndccag_pkg::DIMS_W-1:0] ndims;
  ndccag_pkg::dim_t  dsz [3];
  ndccag_pkg::dim_t  csz [3];
  ndccag_pkg::item_t it;

  always_comb begin
    ndims = (dims_used_r > ndccag_pkg::DIMS_W'(ndccag_pkg::MAX_DIMS)) ?
            ndccag_pkg::DIMS_W'(ndccag_pkg::MAX_DIMS) : dims_used_r;
    for (int k = 0; k < 3; k++) begin
      if (3 - k > int'(ndims)) begin
        dsz[k] = ndccag_pkg::dim_t'(1);
        csz[k] = ndccag_pkg::dim_t'(1);
      end else begin
        dsz[k] = (dim_r[k] == '0) ? ndccag_pkg::dim_t'(1) : dim_r[k];
        csz[k] = (chk_r[k] == '0) ? ndccag_pkg::dim_t'(1) : chk_r[k];
      end
    end
    if (item_r == '0) begin
      it = ndccag_pkg::item_t'(1);
    end else if (item_r > ndccag_pkg::item_t'(ndccag_pkg::MAX_ITEM)) begin
      it = ndccag_pkg::item_t'(ndccag_pkg::MAX_ITEM);
    end else begin
      it = item_r;
    end
  end

  // start transaction fields
  ndccag_pkg::dim_t coord_r [3];
  logic             dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cmd.latch_start) begin
      dir_r <= in_to_chunk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_start) begin
      coord_r[0] <= in_coord0;
      coord_r[1] <= in_coord1;
      coord_r[2] <= in_coord2;
    end
  end

  // grid step: chunk origin products and outer strides
  ndccag_pkg::stride_t prod_r [3];
  ndccag_pkg::stride_t astr0_r, cstr0_r;

  always_ff @(posedge clk) begin
    if (cmd.grid) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= ndccag_pkg::stride_t'(coord_r[k]) * ndccag_pkg::stride_t'(csz[k]);
      end
      astr0_r <= ndccag_pkg::stride_t'(dsz[1]) * ndccag_pkg::stride_t'(dsz[2]);
      cstr0_r <= ndccag_pkg::stride_t'(csz[1]) * ndccag_pkg::stride_t'(csz[2]);
    end
  end

  // clip step: grid check, chunk start and clipped extent
  ndccag_pkg::dim_t start_r [3];
  ndccag_pkg::dim_t ext_r   [3];
  ndccag_pkg::dim_t astr1_r, cstr1_r;
  ndccag_pkg::dim_t rc_r [2];
  logic [DW:0]      end_raw [3];
  ndccag_pkg::dim_t end_clip [3];
  logic             coord_err;

  always_comb begin
    coord_err = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (prod_r[k] >= ndccag_pkg::stride_t'(dsz[k])) coord_err = 1'b1;
      end_raw[k]  = (DW+1)'(prod_r[k][DW-1:0]) + (DW+1)'(csz[k]);
      end_clip[k] = (end_raw[k] > (DW+1)'(dsz[k])) ? dsz[k] : end_raw[k][DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clip) begin
      for (int k = 0; k < 3; k++) begin
        start_r[k] <= prod_r[k][DW-1:0];
        ext_r[k]   <= end_clip[k] - prod_r[k][DW-1:0];
      end
      astr1_r <= dsz[2];
      cstr1_r <= csz[2];
    end
  end

  // odometer over outer and middle dimensions
  logic [DW:0] rc0_inc, rc1_inc;
  logic        last;

  assign rc0_inc = (DW+1)'(rc_r[0]) + (DW+1)'(1);
  assign rc1_inc = (DW+1)'(rc_r[1]) + (DW+1)'(1);
  assign last    = (rc0_inc >= (DW+1)'(ext_r[0])) && (rc1_inc >= (DW+1)'(ext_r[1]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r[0] <= '0;
      rc_r[1] <= '0;
    end else if (cmd.clip) begin
      rc_r[0] <= '0;
      rc_r[1] <= '0;
    end else if (cmd.advance) begin
      if (last) begin
        rc_r[0] <= '0;
        rc_r[1] <= '0;
      end else if (rc1_inc >= (DW+1)'(ext_r[1])) begin
        rc_r[1] <= '0;
        rc_r[0] <= rc0_inc[DW-1:0];
      end else begin
        rc_r[1] <= rc1_inc[DW-1:0];
      end
    end
  end

  // term step: per-dimension offset products
  logic [DW:0]     pos0, pos1;
  logic [T0_W-1:0] t0_r;
  logic [T1_W-1:0] t1_r;
  logic [C0_W-1:0] c0_r;
  logic [C1_W-1:0] c1_r;

  assign pos0 = (DW+1)'(start_r[0]) + (DW+1)'(rc_r[0]);
  assign pos1 = (DW+1)'(start_r[1]) + (DW+1)'(rc_r[1]);

  always_ff @(posedge clk) begin
    if (cmd.term) begin
      t0_r <= T0_W'(pos0) * T0_W'(astr0_r);
      t1_r <= T1_W'(pos1) * T1_W'(astr1_r);
      c0_r <= C0_W'(rc_r[0]) * C0_W'(cstr0_r);
      c1_r <= C1_W'(rc_r[1]) * C1_W'(cstr1_r);
    end
  end

  // sum step: element offsets
  ndccag_pkg::off_t ao_r, co_r;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      ao_r <= OW'(t0_r) + OW'(t1_r) + OW'(start_r[2]);
      co_r <= OW'(c0_r) + OW'(c1_r);
    end
  end

  // result register, scaled to bytes
  ndccag_pkg::off_t ao_bytes, co_bytes;
  ndccag_pkg::run_t rb_bytes;

  assign ao_bytes = OW'(ao_r * OW'(it));
  assign co_bytes = OW'(co_r * OW'(it));
  assign rb_bytes = ndccag_pkg::RUN_W'(ndccag_pkg::RUN_W'(ext_r[2]) *
                                      ndccag_pkg::RUN_W'(it));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_array_offset <= '0;
      out_chunk_offset <= '0;
      out_run_bytes    <= '0;
      out_direction    <= 1'b0;
      out_last         <= 1'b0;
      out_status       <= ndccag_pkg::ST_OK;
    end else if (cmd.load_run) begin
      out_array_offset <= ao_bytes;
      out_chunk_offset <= co_bytes;
      out_run_bytes    <= rb_bytes;
      out_direction    <= dir_r;
      out_last         <= last;
      out_status       <= ndccag_pkg::ST_OK;
    end else if (cmd.load_err) begin
      out_array_offset <= '0;
      out_chunk_offset <= '0;
      out_run_bytes    <= '0;
      out_direction    <= 1'b0;
      out_last         <= 1'b0;
      out_status       <= cmd.err_code;
    end
  end

  assign stat.coord_err = coord_err;
  assign stat.last      = last;

endmodule

### rtl/core/ndccag_ctrl.sv
// controller: sequences start and next transactions, tracks the active chunk
// depends on ndccag_pkg; commands ndccag_dp through dp_cmd_t
module ndccag_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ndccag_pkg::dp_cmd_t   cmd,
  input  ndccag_pkg::dp_stat_t  stat
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GRID = 7'b0000010,
    S_CLIP = 7'b0000100,
    S_TERM = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_ERR  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic                active_r, active_nxt;
  logic                out_valid_r, out_valid_nxt;
  ndccag_pkg::status_t err_code_r, err_code_nxt;
  logic                out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    err_code_nxt  = err_code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.err_code  = err_code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == ndccag_pkg::REQ_NEXT) begin
            if (active_r) begin
              state_nxt = S_TERM;
            end else begin
              err_code_nxt = ndccag_pkg::ST_NOACT;
              state_nxt    = S_ERR;
            end
          end else begin
            cmd.latch_start = 1'b1;
            active_nxt      = 1'b0;
            state_nxt       = S_GRID;
          end
        end
      end
      S_GRID: begin
        cmd.grid  = 1'b1;
        state_nxt = S_CLIP;
      end
      S_CLIP: begin
        cmd.clip = 1'b1;
        if (stat.coord_err) begin
          err_code_nxt = ndccag_pkg::ST_COORD;
          state_nxt    = S_ERR;
        end else begin
          active_nxt = 1'b1;
          state_nxt  = S_TERM;
        end
      end
      S_TERM: begin
        cmd.term  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_run  = 1'b1;
          cmd.advance   = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.last) active_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          cmd.load_err  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      err_code_r  <= ndccag_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      err_code_r  <= err_code_nxt;
    end
  end

endmodule

### tb/nd_chunk_copy_address_generator_tb.sv
// testbench for nd_chunk_copy_address_generator: directed and random chunk walks against a
// built-in descriptor predictor, with bursty input, receiver stalls and a long output hold-off
// depends on ndccag_pkg and the nd_chunk_copy_address_generator rtl
module nd_chunk_copy_address_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ndccag_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1000;
  localparam longint TIMEOUT_NS = 2_000_000;

  // one expected descriptor
  typedef struct {
    off_t    array_off;
    off_t    chunk_off;
    run_t    run_bytes;
    logic    direction;
    logic    last;
    status_t status;
  } run_desc_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_DIM0;
  dim_t     cfg_data = '0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  logic     in_req_type = REQ_START;
  dim_t     in_coord0 = '0;
  dim_t     in_coord1 = '0;
  dim_t     in_coord2 = '0;
  logic     in_to_chunk = 1'b0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  off_t     out_array_offset;
  off_t     out_chunk_offset;
  run_t     out_run_bytes;
  logic     out_direction;
  logic     out_last;
  logic [1:0] out_status;

  // register copy as last written
  dim_t        cfg_dim [3] = '{16'd1, 16'd1, 16'd1};
  dim_t        cfg_chunk [3] = '{16'd1, 16'd1, 16'd1};
  item_t       cfg_item = 5'd1;
  logic [1:0]  cfg_dims = 2'd3;

  // predicted walk state
  longint unsigned chunk_org [3] = '{0, 0, 0};
  longint unsigned chunk_ext [3] = '{0, 0, 0};
  longint unsigned run_pos [2] = '{0, 0};
  longint unsigned arr_pitch [3] = '{0, 0, 0};
  longint unsigned chk_pitch [3] = '{0, 0, 0};
  logic            walk_dir = 1'b0;
  bit              walk_active = 1'b0;

  run_desc_t pending_runs [$];
  int        fail_count = 0;
  int        items_sent = 0;
  bit        gaps_on = 1'b1;
  int        burst_left = 0;
  bit        hold_start = 1'b0;

  nd_chunk_copy_address_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_coord0        (in_coord0),
    .in_coord1        (in_coord1),
    .in_coord2        (in_coord2),
    .in_to_chunk      (in_to_chunk),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_array_offset (out_array_offset),
    .out_chunk_offset (out_chunk_offset),
    .out_run_bytes    (out_run_bytes),
    .out_direction    (out_direction),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // effective sizes: unused leading dims and zero registers act as one
  function automatic longint unsigned eff_dim(int k);
    if (k < 3 - int'(cfg_dims)) return 1;
    return (cfg_dim[k] == '0) ? 1 : cfg_dim[k];
  endfunction

  function automatic longint unsigned eff_chunk(int k);
    if (k < 3 - int'(cfg_dims)) return 1;
    return (cfg_chunk[k] == '0) ? 1 : cfg_chunk[k];
  endfunction

  function automatic longint unsigned item_bytes();
    if (cfg_item == '0) return 1;
    return (cfg_item > MAX_ITEM) ? MAX_ITEM : cfg_item;
  endfunction

  function automatic longint unsigned grid_len(int k);
    return (eff_dim(k) + eff_chunk(k) - 1) / eff_chunk(k);
  endfunction

  function automatic longint unsigned clip_len(int k, longint unsigned g);
    longint unsigned stop;
    stop = (g + 1) * eff_chunk(k);
    if (stop > eff_dim(k)) stop = eff_dim(k);
    return stop - g * eff_chunk(k);
  endfunction

  // emit the current run and step the odometer, middle dim fastest
  function automatic run_desc_t walk_next_run();
    run_desc_t r;
    longint unsigned ao, co, it;
    bit is_last;
    it = item_bytes();
    ao = chunk_org[2] * arr_pitch[2];
    co = 0;
    for (int k = 0; k < 2; k++) begin
      ao += (chunk_org[k] + run_pos[k]) * arr_pitch[k];
      co += run_pos[k] * chk_pitch[k];
    end
    is_last = (run_pos[0] + 1 >= chunk_ext[0]) && (run_pos[1] + 1 >= chunk_ext[1]);
    r.array_off = off_t'(ao * it);
    r.chunk_off = off_t'(co * it);
    r.run_bytes = run_t'(chunk_ext[2] * it);
    r.direction = walk_dir;
    r.last = is_last;
    r.status = ST_OK;
    if (is_last) begin
      walk_active = 1'b0;
      run_pos[0] = 0;
      run_pos[1] = 0;
    end else begin
      run_pos[1]++;
      if (run_pos[1] >= chunk_ext[1]) begin
        run_pos[1] = 0;
        run_pos[0]++;
      end
    end
    return r;
  endfunction

  // descriptor expected for one accepted request
  function automatic run_desc_t predict_descriptor(logic req, dim_t c0, dim_t c1, dim_t c2,
                                                   logic tc);
    run_desc_t r;
    longint unsigned gc [3];
    r.array_off = '0;
    r.chunk_off = '0;
    r.run_bytes = '0;
    r.direction = 1'b0;
    r.last = 1'b0;
    r.status = ST_OK;
    if (req == REQ_NEXT) begin
      if (!walk_active) begin
        r.status = ST_NOACT;
        return r;
      end
      return walk_next_run();
    end
    gc[0] = 64'(c0);
    gc[1] = 64'(c1);
    gc[2] = 64'(c2);
    walk_active = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (gc[k] >= grid_len(k)) begin
        r.status = ST_COORD;
        return r;
      end
      chunk_org[k] = gc[k] * eff_chunk(k);
      chunk_ext[k] = clip_len(k, gc[k]);
    end
    arr_pitch[2] = 1;
    chk_pitch[2] = 1;
    arr_pitch[1] = eff_dim(2);
    chk_pitch[1] = eff_chunk(2);
    arr_pitch[0] = eff_dim(1) * eff_dim(2);
    chk_pitch[0] = eff_chunk(1) * eff_chunk(2);
    run_pos[0] = 0;
    run_pos[1] = 0;
    walk_dir = tc;
    walk_active = 1'b1;
    return walk_next_run();
  endfunction

  // check results first, then queue the prediction for an accepted request
  always @(posedge clk) begin
    run_desc_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_runs.size() == 0) begin
          $error("result with no pending expectation");
          fail_count++;
        end else begin
          want = pending_runs.pop_front();
          if (out_array_offset !== want.array_off) begin
            $error("array_offset mismatch: expected %0h actual %0h",
                   want.array_off, out_array_offset);
            fail_count++;
          end
          if (out_chunk_offset !== want.chunk_off) begin
            $error("chunk_offset mismatch: expected %0h actual %0h",
                   want.chunk_off, out_chunk_offset);
            fail_count++;
          end
          if (out_run_bytes !== want.run_bytes) begin
            $error("run_bytes mismatch: expected %0d actual %0d", want.run_bytes, out_run_bytes);
            fail_count++;
          end
          if (out_direction !== want.direction) begin
            $error("direction mismatch: expected %0b actual %0b", want.direction, out_direction);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0b actual %0b", want.last, out_last);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_runs.push_back(predict_descriptor(in_req_type, in_coord0, in_coord1, in_coord2,
                                                  in_to_chunk));
    end
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin : receiver
    int rx_mode;
    int mode_left;
    int hold_left;
    int tick;
    rx_mode = 0;
    mode_left = 0;
    hold_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((tick % 8) >= 3);
        endcase
      end
    end
  end

  // one request transaction, then an optional gap between bursts
  task automatic send_item(logic req, int c0, int c1, int c2, logic tc);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_coord0 <= dim_t'(c0);
    in_coord1 <= dim_t'(c1);
    in_coord2 <= dim_t'(c2);
    in_to_chunk <= tc;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  // next request with random don't-care fields
  task automatic send_next();
    send_item(REQ_NEXT, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
  endtask

  task automatic write_reg(cfg_idx_t idx, dim_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIM0:      cfg_dim[0] = value;
      CFG_DIM1:      cfg_dim[1] = value;
      CFG_DIM2:      cfg_dim[2] = value;
      CFG_CHUNK0:    cfg_chunk[0] = value;
      CFG_CHUNK1:    cfg_chunk[1] = value;
      CFG_CHUNK2:    cfg_chunk[2] = value;
      CFG_ITEM:      cfg_item = value[ITEM_W-1:0];
      CFG_DIMS_USED: cfg_dims = value[DIMS_W-1:0];
      default:       ;
    endcase
  endtask

  // write every register once the block has drained
  task automatic load_config(int n_used, int d0, int d1, int d2, int k0, int k1, int k2,
                             int item);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_runs.size() != 0) @(posedge clk);
    write_reg(CFG_DIM0, dim_t'(d0));
    write_reg(CFG_DIM1, dim_t'(d1));
    write_reg(CFG_DIM2, dim_t'(d2));
    write_reg(CFG_CHUNK0, dim_t'(k0));
    write_reg(CFG_CHUNK1, dim_t'(k1));
    write_reg(CFG_CHUNK2, dim_t'(k2));
    // upper bits are junk the block must drop
    write_reg(CFG_ITEM, {11'($urandom), 5'(item)});
    write_reg(CFG_DIMS_USED, {14'($urandom), 2'(n_used)});
    cfg_valid <= 1'b0;
  endtask

  // one chunk: mostly a full walk, sometimes abandoned early or overrun
  task automatic send_chunk_walk();
    int g [3];
    int runs;
    int nexts;
    int kind;
    for (int k = 0; k < 3; k++) g[k] = $urandom_range(0, int'(grid_len(k)) - 1);
    runs = int'(clip_len(0, g[0]) * clip_len(1, g[1]));
    kind = $urandom_range(0, 9);
    nexts = runs - 1;
    if (kind == 8 && runs > 1) nexts = $urandom_range(0, runs - 2);
    if (kind == 9) nexts = runs - 1 + $urandom_range(1, 2);
    send_item(REQ_START, g[0], g[1], g[2], 1'($urandom_range(0, 1)));
    repeat (nexts) send_next();
  endtask

  task automatic test_reset_state();
    send_item(REQ_START, 0, 0, 0, 1'b0);
    send_next();
    send_item(REQ_START, 1, 0, 0, 1'b1);
    send_item(REQ_START, 0, 0, 1, 1'b1);
  endtask

  // no dims in use: every dim and chunk size acts as size one
  task automatic test_zero_dims();
    load_config(0, 7, 5, 3, 2, 2, 2, 4);
    send_item(REQ_START, 0, 0, 0, 1'b1);
    send_item(REQ_START, 0, 1, 0, 1'b0);
    send_item(REQ_START, 0, 0, 1, 1'b1);
    send_next();
  endtask

  task automatic test_extreme_sizes();
    load_config(3, 65535, 65535, 65535, 1, 2, 65535, 16);
    send_item(REQ_START, 65534, 32767, 0, 1'b1);
    send_item(REQ_START, 0, 0, 0, 1'b0);
    send_next();
    send_item(REQ_START, 65535, 0, 0, 1'b1);
    send_item(REQ_START, 0, 32768, 0, 1'b1);
    send_item(REQ_START, 0, 0, 1, 1'b0);
  endtask

  // zero sizes act as one, item size zero and above range clamp
  task automatic test_clamped_registers();
    load_config(3, 0, 0, 0, 0, 0, 0, 0);
    send_item(REQ_START, 0, 0, 0, 1'b1);
    load_config(3, 0, 0, 0, 0, 0, 0, 31);
    send_item(REQ_START, 0, 0, 0, 1'b0);
  endtask

  // edge clipping, restart while active, next after the final run
  task automatic test_restart_and_clip();
    load_config(3, 5, 5, 5, 2, 2, 2, 3);
    send_item(REQ_START, 2, 2, 2, 1'b1);
    send_item(REQ_START, 0, 1, 0, 1'b0);
    send_next();
    send_item(REQ_START, 1, 0, 1, 1'b1);
    repeat (3) send_next();
    send_next();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_backpressure();
    load_config(3, 6, 6, 6, 3, 3, 3, 2);
    gaps_on = 1'b0;
    hold_start = 1'b1;
    repeat (3) begin
      send_item(REQ_START, 1, 1, 1, 1'b1);
      repeat (8) send_next();
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int target;
    int k;
    target = items_sent + RANDOM_ITEMS;
    for (int p = 0; items_sent < target; p++) begin
      if (p % 4 == 3)
        load_config($urandom_range(0, 3),
                    ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(1000, 65535),
                    ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(1000, 65535),
                    ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(1000, 65535),
                    $urandom_range(1, 3), $urandom_range(1, 3),
                    ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(1, 65535),
                    ($urandom_range(0, 1) != 0) ? 16 : $urandom_range(0, 31));
      else
        load_config($urandom_range(0, 3),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6),
                    $urandom_range(0, 31));
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (85) begin
        case ($urandom_range(0, 9))
          8: begin
            // stray start: fully random coordinates or one just past the grid
            if ($urandom_range(0, 1) != 0) begin
              send_item(REQ_START, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
            end else begin
              k = $urandom_range(0, 2);
              send_item(REQ_START, (k == 0) ? int'(grid_len(0)) : 0,
                        (k == 1) ? int'(grid_len(1)) : 0,
                        (k == 2) ? int'(grid_len(2)) : 0, 1'($urandom_range(0, 1)));
            end
          end
          9: send_next();
          default: send_chunk_walk();
        endcase
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_zero_dims();
    test_extreme_sizes();
    test_clamped_registers();
    test_restart_and_clip();
    test_output_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("nd_chunk_copy_address_generator_tb: PASS");
    end else begin
      $display("nd_chunk_copy_address_generator_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("nd_chunk_copy_address_generator_tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ndccag_pkg.sv
rtl/core/ndccag_dp.sv
rtl/core/ndccag_ctrl.sv
rtl/core/nd_chunk_copy_address_generator.sv
tb/nd_chunk_copy_address_generator_tb.sv
